// ----- rtl/dsd_pkg.sv -----
// ----------------------------------------------------------------------------
// Delta signal decoder package
// Shared types and result codes for the delta signal decoder blocks.
// ----------------------------------------------------------------------------
package dsd_pkg;

  // Result status codes.
  localparam logic [1:0] ST_SAMPLE = 2'd0;
  localparam logic [1:0] ST_MARKER = 2'd1;
  localparam logic [1:0] ST_JUMP   = 2'd2;
  localparam logic [1:0] ST_ERROR  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_MARKER = 2'd0;
  localparam logic [1:0] REG_END    = 2'd1;
  localparam logic [1:0] REG_JUMP   = 2'd2;
  localparam logic [1:0] REG_GAIN   = 2'd3;

  localparam int unsigned LEVEL_W  = 32;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned SCALED_W = 56;
  localparam int unsigned INDEX_W  = 32;

  // Decoder configuration.
  typedef struct packed {
    logic [7:0]        marker_code;
    logic [7:0]        end_code;
    logic [7:0]        jump_code;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  // One decoded beat, before scaling.
  typedef struct packed {
    logic [1:0]         status;
    logic [LEVEL_W-1:0] level;
    logic [INDEX_W-1:0] index;
  } beat_t;

endpackage

// ----- rtl/dsd_decode.sv -----
// ----------------------------------------------------------------------------
// Delta signal decoder: segment decode stage
// Classifies each segment, updates the running level and sample index, and
// registers the decoded beat for the scaling stage.
// ----------------------------------------------------------------------------
module dsd_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  dsd_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   in_segment,
  input  logic          in_first,
  output logic          s1_valid,
  output dsd_pkg::beat_t s1_beat,
  input  logic          s1_take
);

  // Record phase. Idle also covers a record whose start was bad.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_JHI  = 2'd2;
  localparam logic [1:0] PH_JLO  = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] jump_high_r, jump_high_nxt;
  logic [31:0] level_r, level_nxt;
  logic [31:0] count_r, count_nxt;
  logic        s1_valid_r;
  dsd_pkg::beat_t beat_r, beat_nxt;

  logic [7:0]  seg_hi;
  logic [7:0]  seg_lo;
  logic        is_marker;
  logic        is_jump;
  logic [32:0] delta_sum;
  logic [31:0] delta_level;
  logic [31:0] count_inc;
  logic        accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_valid_r || s1_take;
  assign s1_valid = s1_valid_r;
  assign s1_beat  = beat_r;

  // Segment classification.
  assign seg_hi    = in_segment[15:8];
  assign seg_lo    = in_segment[7:0];
  assign is_marker = (seg_hi == cfg.marker_code) && (seg_lo != cfg.end_code);
  assign is_jump   = (seg_hi == cfg.jump_code) && (seg_lo == cfg.end_code);

  // Saturating delta add and saturating index increment.
  assign delta_sum = {level_r[31], level_r} + {{17{in_segment[15]}}, in_segment};
  always_comb begin
    if (delta_sum[32] != delta_sum[31]) begin
      delta_level = delta_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      delta_level = delta_sum[31:0];
    end
  end
  assign count_inc = (count_r == 32'hFFFF_FFFF) ? count_r : count_r + 32'd1;

  // Next state and decoded beat for one segment.
  always_comb begin
    phase_nxt       = phase_r;
    jump_high_nxt   = jump_high_r;
    level_nxt       = level_r;
    count_nxt       = count_r;
    beat_nxt.status = dsd_pkg::ST_ERROR;
    beat_nxt.level  = level_r;
    beat_nxt.index  = count_r;
    if (in_first) begin
      level_nxt      = '0;
      count_nxt      = '0;
      jump_high_nxt  = '0;
      beat_nxt.level = '0;
      beat_nxt.index = '0;
      if (is_marker) begin
        phase_nxt       = PH_RUN;
        beat_nxt.status = dsd_pkg::ST_MARKER;
      end else begin
        phase_nxt       = PH_IDLE;
        beat_nxt.status = dsd_pkg::ST_ERROR;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          beat_nxt.status = dsd_pkg::ST_ERROR;
        end
        PH_JHI: begin
          jump_high_nxt   = in_segment;
          phase_nxt       = PH_JLO;
          beat_nxt.status = dsd_pkg::ST_JUMP;
        end
        PH_JLO: begin
          level_nxt       = {jump_high_r, in_segment};
          count_nxt       = count_inc;
          phase_nxt       = PH_RUN;
          beat_nxt.status = dsd_pkg::ST_SAMPLE;
          beat_nxt.level  = {jump_high_r, in_segment};
        end
        PH_RUN: begin
          priority if (is_marker) begin
            beat_nxt.status = dsd_pkg::ST_MARKER;
          end else if (is_jump) begin
            phase_nxt       = PH_JHI;
            beat_nxt.status = dsd_pkg::ST_JUMP;
          end else begin
            level_nxt       = delta_level;
            count_nxt       = count_inc;
            beat_nxt.status = dsd_pkg::ST_SAMPLE;
            beat_nxt.level  = delta_level;
          end
        end
        default: begin
          beat_nxt.status = dsd_pkg::ST_ERROR;
        end
      endcase
    end
  end

  // Decoder state and stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      jump_high_r <= '0;
      level_r     <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        jump_high_r <= jump_high_nxt;
        level_r     <= level_nxt;
        count_r     <= count_nxt;
        s1_valid_r  <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r  <= 1'b0;
      end
    end
  end

  // Beat payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r <= beat_nxt;
    end
  end

endmodule

// ----- rtl/dsd_scale.sv -----
// ----------------------------------------------------------------------------
// Delta signal decoder: scaling stage
// Multiplies the level by the Q0.24 gain and holds the result beat in the
// output register.
// ----------------------------------------------------------------------------
module dsd_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dsd_pkg::GAIN_W-1:0]  gain,
  input  logic                        s1_valid,
  input  dsd_pkg::beat_t              s1_beat,
  output logic                        s1_take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic signed [dsd_pkg::LEVEL_W-1:0]  out_level,
  output logic signed [dsd_pkg::SCALED_W-1:0] out_scaled_value,
  output logic [dsd_pkg::INDEX_W-1:0] out_sample_index
);

  logic                                out_valid_r;
  logic [1:0]                          status_r;
  logic [dsd_pkg::LEVEL_W-1:0]         level_r;
  logic [dsd_pkg::SCALED_W-1:0]        scaled_r;
  logic [dsd_pkg::INDEX_W-1:0]         index_r;
  logic signed [dsd_pkg::SCALED_W:0]   product;
  logic                                load;

  // The output register is free when empty or drained this cycle.
  assign s1_take = !out_valid_r || out_ready;
  assign load    = s1_valid && s1_take;

  // Signed level times unsigned gain; the exact product fits in 56 bits.
  assign product = $signed(s1_beat.level) * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_take) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= s1_beat.status;
      level_r  <= s1_beat.level;
      scaled_r <= product[dsd_pkg::SCALED_W-1:0];
      index_r  <= s1_beat.index;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_level        = $signed(level_r);
  assign out_scaled_value = $signed(scaled_r);
  assign out_sample_index = index_r;

endmodule

// ----- rtl/delta_signal_decoder.sv -----
// ----------------------------------------------------------------------------
// Delta signal decoder
// Decodes a 16-bit delta-coded signal stream into levels, scaled levels and
// sample indexes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_segment, in_first) arrive on a valid/ready channel; each
//   accepted beat yields exactly one result beat on the out_ channel.
//   Registers (marker code, end code, jump code and the Q0.24 gain) are
//   written through cfg_we/cfg_index/cfg_wdata; the user must write them
//   only while the block is idle, which the block itself does not enforce.
//   Beats pass two register stages, decode then gain multiply, at one beat
//   per cycle while out_ready is high; the running level and index update in
//   the decode stage, and the 32x24 multiplier has a stage of its own.
//   Reset clears the registers, the level, the index and the pipeline; the
//   block then ignores segments until a record opens with a valid marker.
//   When out_ready is low, the result is held and the decode stage fills;
//   in_ready drops only when both stages hold beats.
// ----------------------------------------------------------------------------
module delta_signal_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_segment,
  input  logic               in_first,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_level,
  output logic signed [55:0] out_scaled_value,
  output logic [31:0]        out_sample_index
);

  dsd_pkg::cfg_t  cfg_r;
  dsd_pkg::beat_t s1_beat;
  logic           s1_valid;
  logic           s1_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsd_pkg::REG_MARKER: cfg_r.marker_code <= cfg_wdata[7:0];
        dsd_pkg::REG_END:    cfg_r.end_code    <= cfg_wdata[7:0];
        dsd_pkg::REG_JUMP:   cfg_r.jump_code   <= cfg_wdata[7:0];
        dsd_pkg::REG_GAIN:   cfg_r.gain        <= cfg_wdata;
        default:             cfg_r             <= cfg_r;
      endcase
    end
  end

  dsd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_segment (in_segment),
    .in_first   (in_first),
    .s1_valid   (s1_valid),
    .s1_beat    (s1_beat),
    .s1_take    (s1_take)
  );

  dsd_scale u_scale (
    .clk              (clk),
    .rst_n            (rst_n),
    .gain             (cfg_r.gain),
    .s1_valid         (s1_valid),
    .s1_beat          (s1_beat),
    .s1_take          (s1_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_level        (out_level),
    .out_scaled_value (out_scaled_value),
    .out_sample_index (out_sample_index)
  );

`ifndef SYNTH
  // An ignored or bad record always sits at level zero and index zero.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dsd_pkg::ST_ERROR) |->
      (out_level == 32'sd0) && (out_sample_index == 32'd0))
    else $error("error beat with nonzero level or index");

  // A zero level always scales to zero.
  a_scale_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_level == 32'sd0) |-> (out_scaled_value == 56'sd0))
    else $error("zero level gave nonzero scaled value");

  // A draining output never blocks the input.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // A beat taken from the decode stage is valid at the output in the next cycle.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && s1_take |=> out_valid)
    else $error("decoded beat lost before output register");
`endif

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Delta signal decoder testbench
// Drives segment beats into the decoder and checks every result beat
// against a cycle-free predictor of the decoding rules. A short directed
// walk covers record starts, markers, jumps, saturation and truncated
// jumps. A longer random run follows over several register settings with
// bursty input, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES = 6;
  localparam int unsigned BEATS_PER_PHASE = 192;
  localparam int unsigned LONG_HOLD = 300;
  localparam longint LEVEL_TOP = 64'sd2147483647;
  localparam longint LEVEL_BOTTOM = -64'sd2147483648;
  localparam int unsigned LEVEL_W = dsd_pkg::LEVEL_W;
  localparam int unsigned GAIN_W = dsd_pkg::GAIN_W;
  localparam int unsigned SCALED_W = dsd_pkg::SCALED_W;
  localparam int unsigned INDEX_W = dsd_pkg::INDEX_W;

  typedef enum logic [1:0] {
    RS_IDLE,
    RS_RUN,
    RS_JUMP_HI,
    RS_JUMP_LO
  } rec_state_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [LEVEL_W-1:0] level;
    logic signed [SCALED_W-1:0] scaled;
    logic [INDEX_W-1:0]        index;
  } result_t;

  typedef struct packed {
    logic                      first;
    logic [15:0]               seg;
    logic                      typed;
    logic [1:0]                status;
    logic signed [LEVEL_W-1:0] level;
    logic [INDEX_W-1:0]        index;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [23:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [15:0] in_segment;
  logic in_first;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_status;
  logic signed [31:0] out_level;
  logic signed [55:0] out_scaled_value;
  logic [31:0] out_sample_index;

  // Register copies held by the predictor.
  logic [7:0] reg_marker;
  logic [7:0] reg_end;
  logic [7:0] reg_jump;
  logic [GAIN_W-1:0] reg_gain;

  // Decoder state held by the predictor.
  rec_state_t rec_state;
  logic [15:0] jump_hi_word;
  logic signed [LEVEL_W-1:0] run_level;
  logic [INDEX_W-1:0] next_idx;

  result_t expected_q[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned jump_words_left = 0;
  bit long_hold_req = 1'b0;

  delta_signal_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_segment       (in_segment),
    .in_first         (in_first),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_level        (out_level),
    .out_scaled_value (out_scaled_value),
    .out_sample_index (out_sample_index)
  );

  always #10 clk = ~clk;

  // Directed walk, written for marker and jump codes 0xA5, end code 0x5A
  // and unity gain, so a typed scaled value equals the level.
  dir_row_t dir_rows [25] = '{
    // No record opened since reset: ignored.
    '{1'b0, 16'h1234, 1'b1, dsd_pkg::ST_ERROR, 32'sd0, 32'd0},
    // A record start that looks like a jump is not a marker.
    '{1'b1, 16'hA55A, 1'b1, dsd_pkg::ST_ERROR, 32'sd0, 32'd0},
    '{1'b0, 16'h0005, 1'b1, dsd_pkg::ST_ERROR, 32'sd0, 32'd0},
    '{1'b1, 16'hA501, 1'b1, dsd_pkg::ST_MARKER, 32'sd0, 32'd0},
    '{1'b0, 16'h0005, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    '{1'b0, 16'hFFFF, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    '{1'b0, 16'hA500, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    // Jump to the top of the level range, then saturate upward.
    '{1'b0, 16'hA55A, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    '{1'b0, 16'h7FFF, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    '{1'b0, 16'hFFFF, 1'b1, dsd_pkg::ST_SAMPLE, 32'sh7FFF_FFFF, 32'd2},
    '{1'b0, 16'h7FFF, 1'b1, dsd_pkg::ST_SAMPLE, 32'sh7FFF_FFFF, 32'd3},
    // Jump to the bottom of the range, then saturate downward.
    '{1'b0, 16'hA55A, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    '{1'b0, 16'h8000, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    '{1'b0, 16'h0000, 1'b1, dsd_pkg::ST_SAMPLE, 32'sh8000_0000, 32'd4},
    '{1'b0, 16'h8000, 1'b1, dsd_pkg::ST_SAMPLE, 32'sh8000_0000, 32'd5},
    '{1'b0, 16'h0000, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    '{1'b0, 16'hA55A, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    // A new record drops the pending jump.
    '{1'b1, 16'hA5FF, 1'b1, dsd_pkg::ST_MARKER, 32'sd0, 32'd0},
    '{1'b0, 16'hA55A, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    '{1'b0, 16'h1234, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    // A bad record start halfway through a jump.
    '{1'b1, 16'h00FF, 1'b1, dsd_pkg::ST_ERROR, 32'sd0, 32'd0},
    '{1'b0, 16'h8000, 1'b1, dsd_pkg::ST_ERROR, 32'sd0, 32'd0},
    '{1'b1, 16'hA500, 1'b1, dsd_pkg::ST_MARKER, 32'sd0, 32'd0},
    '{1'b0, 16'h7FFF, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0},
    '{1'b0, 16'hA5A5, 1'b0, dsd_pkg::ST_SAMPLE, 32'sd0, 32'd0}
  };

  // Decode one segment with the predictor and advance its state.
  function automatic result_t decode_segment(input logic first, input logic [15:0] seg);
    result_t res;
    logic is_marker;
    logic is_jump;
    longint sum;
    is_marker = (seg[15:8] == reg_marker) && (seg[7:0] != reg_end);
    is_jump = (seg[15:8] == reg_jump) && (seg[7:0] == reg_end);
    res.status = dsd_pkg::ST_SAMPLE;
    if (first) begin
      run_level = '0;
      next_idx = '0;
      jump_hi_word = '0;
      if (is_marker) begin
        rec_state = RS_RUN;
        res.status = dsd_pkg::ST_MARKER;
      end else begin
        rec_state = RS_IDLE;
        res.status = dsd_pkg::ST_ERROR;
      end
    end else if (rec_state == RS_IDLE) begin
      res.status = dsd_pkg::ST_ERROR;
    end else if (rec_state == RS_JUMP_HI) begin
      jump_hi_word = seg;
      rec_state = RS_JUMP_LO;
      res.status = dsd_pkg::ST_JUMP;
    end else if (rec_state == RS_JUMP_LO) begin
      run_level = {jump_hi_word, seg};
      rec_state = RS_RUN;
    end else if (is_marker) begin
      res.status = dsd_pkg::ST_MARKER;
    end else if (is_jump) begin
      rec_state = RS_JUMP_HI;
      res.status = dsd_pkg::ST_JUMP;
    end else begin
      sum = longint'(run_level) + longint'($signed(seg));
      if (sum > LEVEL_TOP) sum = LEVEL_TOP;
      if (sum < LEVEL_BOTTOM) sum = LEVEL_BOTTOM;
      run_level = sum[31:0];
    end
    res.level = run_level;
    res.scaled = SCALED_W'(longint'(run_level) * longint'(reg_gain));
    res.index = next_idx;
    if (res.status == dsd_pkg::ST_SAMPLE && next_idx != '1) next_idx = next_idx + 1'b1;
    return res;
  endfunction

  // Random segment source: mostly well-formed records with random content,
  // plus noise and broken jumps.
  function automatic logic [16:0] next_stimulus();
    logic first;
    logic [15:0] seg;
    logic [7:0] lo;
    int unsigned roll;
    roll = $urandom_range(99);
    first = 1'b0;
    lo = 8'($urandom_range(255));
    if (lo == reg_end) lo = lo + 8'd1;
    if (jump_words_left > 0 && roll < 3) begin
      // Record start cutting a jump short.
      jump_words_left = 0;
      first = 1'b1;
      seg = {reg_marker, lo};
    end else if (jump_words_left > 0) begin
      jump_words_left--;
      case ($urandom_range(3))
        0: seg = 16'h7FFF;
        1: seg = 16'h8000;
        2: seg = 16'($urandom_range(7));
        default: seg = 16'($urandom);
      endcase
    end else if (roll < 4) begin
      first = 1'b1;
      seg = ($urandom_range(5) == 0) ? 16'($urandom) : {reg_marker, lo};
    end else if (roll < 9) begin
      seg = 16'($urandom);
    end else if (roll < 15) begin
      seg = {reg_marker, lo};
    end else if (roll < 22) begin
      seg = {reg_jump, reg_end};
      jump_words_left = 2;
    end else begin
      case ($urandom_range(9))
        5, 6, 7: seg = 16'($urandom);
        8: seg = 16'h7FFF;
        9: seg = 16'h8000;
        default: seg = 16'($urandom_range(64) - 32);
      endcase
    end
    return {first, seg};
  endfunction

  // Write all four registers, one per cycle, and mirror them.
  task automatic apply_config(input logic [7:0] marker, input logic [7:0] endc,
                              input logic [7:0] jump, input logic [23:0] gain);
    logic [23:0] vals [4];
    vals = '{{16'd0, marker}, {16'd0, endc}, {16'd0, jump}, gain};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      case (2'(i))
        dsd_pkg::REG_MARKER: reg_marker = vals[i][7:0];
        dsd_pkg::REG_END: reg_end = vals[i][7:0];
        dsd_pkg::REG_JUMP: reg_jump = vals[i][7:0];
        dsd_pkg::REG_GAIN: reg_gain = vals[i];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one beat and hold it until the block takes it.
  task automatic offer_beat(input logic first, input logic [15:0] seg);
    @(negedge clk);
    in_valid <= 1'b1;
    in_first <= first;
    in_segment <= seg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_input(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Stop offering and wait until every expected beat has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: switches among stall patterns, with one long hold-off on request.
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(3);
        mode_left = $urandom_range(300, 50);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(1));
          2: out_ready <= (tick % 3) != 0;
          default: out_ready <= ($urandom_range(4) == 0);
        endcase
      end
    end
  end

  // Result checker: each beat against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation: status %0d level %0d",
               out_status, out_level);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_level);
          fail_count++;
        end
        if (out_scaled_value !== want.scaled) begin
          $error("scaled_value: expected %0d, got %0d", want.scaled, out_scaled_value);
          fail_count++;
        end
        if (out_sample_index !== want.index) begin
          $error("sample_index: expected %0d, got %0d", want.index, out_sample_index);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Main sequence: reset, directed walk, then random phases.
  initial begin : stimulus
    result_t got;
    logic [16:0] item;
    int unsigned counted;
    int unsigned burst_left;
    bit bursty;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_first = 1'b0;
    in_segment = '0;
    reg_marker = '0;
    reg_end = '0;
    reg_jump = '0;
    reg_gain = '0;
    rec_state = RS_IDLE;
    jump_hi_word = '0;
    run_level = '0;
    next_idx = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Marker and jump codes share one value to exercise the overlap rule.
    apply_config(8'hA5, 8'h5A, 8'hA5, 24'd1);
    foreach (dir_rows[i]) begin
      offer_beat(dir_rows[i].first, dir_rows[i].seg);
      got = decode_segment(dir_rows[i].first, dir_rows[i].seg);
      if (dir_rows[i].typed) begin
        got.status = dir_rows[i].status;
        got.level = dir_rows[i].level;
        got.scaled = SCALED_W'(dir_rows[i].level);
        got.index = dir_rows[i].index;
      end
      expected_q.push_back(got);
    end
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_config(8'h00, 8'h00, 8'h00, 24'h000000);
        1: apply_config(8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
        2: apply_config(8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
        3: begin
          item[7:0] = 8'($urandom);
          apply_config(item[7:0], 8'($urandom), item[7:0], 24'h800000);
        end
        4: apply_config(8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom_range(255)));
        default: apply_config(8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
      endcase
      // Fresh record at the start of each phase.
      jump_words_left = 0;
      bursty = (p != 1);
      if (p == 2) long_hold_req = 1'b1;
      counted = 0;
      burst_left = 0;
      while (counted < BEATS_PER_PHASE) begin
        if (burst_left == 0) begin
          if (bursty) idle_input($urandom_range(8));
          burst_left = $urandom_range(40, 1);
        end
        burst_left--;
        if (p == 3 && counted == BEATS_PER_PHASE / 2) wait_drained();
        item = (counted == 0) ? {1'b1, reg_marker, ~reg_end} : next_stimulus();
        offer_beat(item[16], item[15:0]);
        got = decode_segment(item[16], item[15:0]);
        expected_q.push_back(got);
        counted++;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
